// ===== hdl/tppq_pkg.sv =====
// ----------------------------------------------------------------------------
// tppq_pkg
// Shared constants, codes and types of the two-level priority packet queue.
// ----------------------------------------------------------------------------
package tppq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int MAX_LENGTH    = 255;
  localparam int PAYLOAD_WIDTH = 32;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_W = 8;

  // operation codes
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_PEEK = 2'd1;
  localparam logic [1:0] OP_POP  = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  // per-cell commands
  typedef logic [1:0] cell_cmd_t;
  localparam cell_cmd_t CELL_HOLD      = 2'd0;
  localparam cell_cmd_t CELL_LOAD      = 2'd1;
  localparam cell_cmd_t CELL_FROM_PREV = 2'd2;
  localparam cell_cmd_t CELL_FROM_NEXT = 2'd3;

  typedef struct packed {
    logic [PAYLOAD_WIDTH-1:0] payload;
    logic [LEN_W-1:0]         length;
  } entry_t;

  // what each cell sees from the controller
  typedef struct packed {
    cell_cmd_t cmd;
    entry_t    load_entry;
  } cell_ctrl_t;

endpackage

// ===== hdl/tppq_cell.sv =====
// ----------------------------------------------------------------------------
// tppq_cell
// One queue slot: holds an entry, loads a new one, or takes its neighbour's.
// ----------------------------------------------------------------------------
module tppq_cell
  import tppq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     prev_entry,
  input  entry_t     next_entry,
  output entry_t     entry
);

  entry_t entry_next;

  always_comb begin
    case (ctrl.cmd)
      CELL_HOLD:      entry_next = entry;
      CELL_LOAD:      entry_next = ctrl.load_entry;
      CELL_FROM_PREV: entry_next = prev_entry;
      CELL_FROM_NEXT: entry_next = next_entry;
      default:        entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== hdl/two_priority_packet_queue.sv =====
// ----------------------------------------------------------------------------
// two_priority_packet_queue
// Transmit queue with two priority levels, built as a row of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one operation per item: push
//   (with high_priority, payload, length), peek or pop. Output channel
//   (out_valid/out_stall) returns one result item per input item: ok,
//   front_payload/front_length (peek only) and the empty/full flags after
//   the operation.
//   Slot 0 of the cell row is always the front. A pop shifts every cell
//   forward one place; a high push loads at the boundary after the high
//   entries and shifts the cells behind it back one place; a normal push
//   loads at the tail. All cells move in the same cycle.
//   The result is registered: out_valid rises the cycle after acceptance;
//   one item is taken every cycle unless a held result is stalled. The
//   input stalls only while a result is held and the receiver stalls the
//   output, so a stalled result never blocks more than that single register.
//   Reset empties the queue and drops any pending result; slot contents are
//   not cleared and are never read while empty.
// ----------------------------------------------------------------------------
module two_priority_packet_queue
  import tppq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic        high_priority,
  input  logic [31:0] payload,
  input  logic [15:0] length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ok,
  output logic [31:0] front_payload,
  output logic [7:0]  front_length,
  output logic        is_empty,
  output logic        is_full
);

  logic [OCC_W-1:0] occupancy, occupancy_next;
  logic [IDX_W-1:0] high_count, high_count_next;   // boundary offset from front, mod depth

  entry_t     cell_q    [QUEUE_DEPTH];
  cell_ctrl_t cell_ctrl [QUEUE_DEPTH];

  logic             accept;
  logic             push_ok, peek_ok, pop_ok;
  logic [IDX_W-1:0] insert_pos;
  entry_t           new_entry;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign push_ok = (operation == OP_PUSH) && (occupancy < OCC_W'(QUEUE_DEPTH))
                   && (length <= 16'(MAX_LENGTH));
  assign peek_ok = (operation == OP_PEEK) && (occupancy != '0);
  assign pop_ok  = (operation == OP_POP) && (occupancy != '0);

  assign insert_pos        = high_priority ? high_count : occupancy[IDX_W-1:0];
  assign new_entry.payload = PAYLOAD_WIDTH'(payload);
  assign new_entry.length  = LEN_W'(length);

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cell_ctrl[i].load_entry = new_entry;
      cell_ctrl[i].cmd        = CELL_HOLD;
      if (accept && pop_ok) begin
        cell_ctrl[i].cmd = CELL_FROM_NEXT;
      end else if (accept && push_ok) begin
        if (IDX_W'(i) == insert_pos) begin
          cell_ctrl[i].cmd = CELL_LOAD;
        end else if (IDX_W'(i) > insert_pos) begin
          cell_ctrl[i].cmd = CELL_FROM_PREV;
        end
      end
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    entry_t prev_e, next_e;
    if (g == 0) begin : g_first
      assign prev_e = new_entry;
    end else begin : g_mid
      assign prev_e = cell_q[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign next_e = cell_q[g];
    end else begin : g_inner
      assign next_e = cell_q[g+1];
    end
    tppq_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[g]),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .entry      (cell_q[g])
    );
  end

  always_comb begin
    occupancy_next  = occupancy;
    high_count_next = high_count;
    if (accept && push_ok) begin
      occupancy_next = occupancy + 1'b1;
      if (high_priority) begin
        high_count_next = (high_count == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : high_count + 1'b1;
      end
    end else if (accept && pop_ok) begin
      occupancy_next = occupancy - 1'b1;
      // front at the boundary: boundary moves with it
      if (high_count != '0) begin
        high_count_next = high_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy  <= '0;
      high_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      occupancy  <= occupancy_next;
      high_count <= high_count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok            <= push_ok || peek_ok || pop_ok;
      front_payload <= peek_ok ? 32'(cell_q[0].payload) : '0;
      front_length  <= peek_ok ? cell_q[0].length : '0;
      is_empty      <= (occupancy_next == '0);
      is_full       <= (occupancy_next == OCC_W'(QUEUE_DEPTH));
    end
  end

`ifndef ASSERT_OFF
  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    (occupancy <= OCC_W'(QUEUE_DEPTH)) && (OCC_W'(high_count) <= occupancy))
    else $error("occupancy or boundary out of range");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    accept && pop_ok |=> occupancy == $past(occupancy) - 1'b1)
    else $error("pop did not remove one entry");

  a_push_inc: assert property (@(posedge clk) disable iff (rst)
    accept && push_ok |=> occupancy == $past(occupancy) + 1'b1)
    else $error("push did not add one entry");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_empty && is_full))
    else $error("queue reported empty and full together");

  a_front_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> (front_payload == '0) && (front_length == '0))
    else $error("failed item carries front data");
`endif

endmodule
